/* rtl/core/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked outside reset.
`define LVA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lbl failed");

// Property that must hold in the cycle after reset is seen.
`define LVA_ASSERT_RST(lbl, cons) \
  lbl: assert property (@(posedge clk) !rst_n |=> (cons)) \
    else $error("lbl failed");

`endif

/* rtl/core/lva_pkg.sv */
`default_nettype none
package lva_pkg;

  localparam int SqrtStages     = 34;
  localparam int DirStages      = 17;
  localparam int RecipFront     = 4;
  localparam int RecipDivStages = 32;
  localparam int RecipLat       = RecipFront + RecipDivStages;
  localparam int DirDelay       = RecipLat - DirStages;

  localparam logic [2:0] CFG_POS_X  = 3'd0;
  localparam logic [2:0] CFG_POS_Y  = 3'd1;
  localparam logic [2:0] CFG_POS_Z  = 3'd2;
  localparam logic [2:0] CFG_COEF_A = 3'd3;
  localparam logic [2:0] CFG_COEF_B = 3'd4;
  localparam logic [2:0] CFG_COEF_C = 3'd5;

  localparam logic [31:0] CoefCReset = 32'h0001_0000;
  localparam logic [31:0] AttenMax   = 32'hFFFF_FFFF;
  localparam logic [64:0] RecipOne   = 65'h1_0000_0000_0000_0000;

  typedef struct packed {
    logic [31:0] mag_x;
    logic [31:0] mag_y;
    logic [31:0] mag_z;
    logic        neg_x;
    logic        neg_y;
    logic        neg_z;
    logic        at;
  } ofs_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } coef_t;

endpackage
`default_nettype wire

/* rtl/core/lva_recip.sv */
`default_nettype none
module lva_recip
  import lva_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [32:0] dist_i,
  input  wire coef_t       coef_i,
  output logic [31:0]      atten_o,
  output logic             sat_o
);

  typedef struct packed {
    logic [64:0] rem;
    logic [64:0] n;
    logic [31:0] q;
    logic        sat;
    logic        big;
  } rd_t;

  // front: denominator N = A*D*D + B*D*2^16 + C*2^32
  logic [64:0] ad_r, bd0_r;
  logic [32:0] d0_r;
  logic [31:0] c0_r;
  logic [65:0] ph_r;
  logic [64:0] pl_r, bd1_r;
  logic [31:0] c1_r;
  logic [97:0] aterm_r;
  logic [81:0] lterm_r;
  logic [98:0] n_nxt;
  rd_t         f3_r, f3_nxt;
  rd_t         rd_r [RecipDivStages];

  always_ff @(posedge clk) begin
    if (en) begin
      ad_r    <= 65'(coef_i.a) * 65'(dist_i);
      bd0_r   <= 65'(coef_i.b) * 65'(dist_i);
      d0_r    <= dist_i;
      c0_r    <= coef_i.c;
      ph_r    <= 66'(ad_r[64:32]) * 66'(d0_r);
      pl_r    <= 65'(ad_r[31:0]) * 65'(d0_r);
      bd1_r   <= bd0_r;
      c1_r    <= c0_r;
      aterm_r <= {ph_r, 32'b0} + 98'(pl_r);
      lterm_r <= 82'({bd1_r, 16'b0}) + 82'({c1_r, 32'b0});
      f3_r    <= f3_nxt;
    end
  end

  always_comb begin
    n_nxt      = 99'(aterm_r) + 99'(lterm_r);
    f3_nxt.rem = RecipOne;
    f3_nxt.n   = n_nxt[64:0];
    f3_nxt.q   = '0;
    // N <= 2^32 (zero included): quotient would not fit
    f3_nxt.sat = (n_nxt[98:32] == '0) || (n_nxt[98:33] == '0 && n_nxt[31:0] == '0);
    // N > 2^64: quotient floors to zero
    f3_nxt.big = (n_nxt[98:65] != '0) || (n_nxt[64] && n_nxt[63:0] != '0);
  end

  // restoring divide of 2^64 by N, one quotient bit per stage
  for (genvar k = 0; k < RecipDivStages; k++) begin : g_div
    localparam int B = RecipDivStages - 1 - k;
    rd_t         src, nxt;
    logic [96:0] dv;
    logic        ge;
    if (k == 0) begin : g_first
      assign src = f3_r;
    end else begin : g_rest
      assign src = rd_r[k-1];
    end
    always_comb begin
      dv      = 97'(src.n) << B;
      ge      = 97'(src.rem) >= dv;
      nxt     = src;
      nxt.rem = ge ? src.rem - dv[64:0] : src.rem;
      nxt.q   = {src.q[30:0], ge};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rd_r[k] <= nxt;
      end
    end
  end

  always_comb begin
    sat_o   = rd_r[RecipDivStages-1].sat;
    atten_o = rd_r[RecipDivStages-1].sat ? AttenMax :
              rd_r[RecipDivStages-1].big ? '0 : rd_r[RecipDivStages-1].q;
  end

endmodule
`default_nettype wire

/* rtl/core/light_vector_and_attenuation.sv */
`default_nettype none
// Point light direction, distance and quadratic attenuation. Each input word is
// one surface point (x,y,z, signed Q16.16); each output word gives the unit
// vector from the point to the light (Q1.16), the distance (Q16.16, floor of
// the exact root) and 1/(a*d*d + b*d + c) in Q16.16, saturating to all ones
// with a flag when the denominator is zero or too small. A point sitting on
// the light gives a zero vector, zero distance and the at_light flag. The
// block is a fully pipelined datapath taking one word per cycle; backpressure
// on out_tready stalls the whole pipe and nothing is dropped. It is built of
// three offset/square/sum stages, the 34 one-bit square-root stages, the
// 36-stage attenuation path (four multiply/add stages and a 32-stage radix-2
// divider) and the output register; the direction dividers (17 stages) run
// beside the attenuation path. Light position and coefficients are written
// over the cfg port, by the user only while no word is in flight; the block
// does not enforce this. Indexes above 5 are ignored. cfg_ready is always high.
module light_vector_and_attenuation
  import lva_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  // point_x [31:0], point_y [63:32], point_z [95:64]
  input  wire logic [95:0]  in_tdata,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // dir_x [17:0], dir_y [35:18], dir_z [53:36], distance [86:54],
  // atten [118:87], zero pad [119]
  output logic [119:0]      out_tdata,
  // atten_saturated [0], at_light [1]
  output logic [1:0]        out_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);

  typedef struct packed {
    logic [35:0] rem;
    logic [33:0] root;
    logic [67:0] rad;
    ofs_t        o;
  } sq_t;

  typedef struct packed {
    logic [47:0] rem_x;
    logic [47:0] rem_y;
    logic [47:0] rem_z;
    logic [16:0] q_x;
    logic [16:0] q_y;
    logic [16:0] q_z;
    logic [32:0] distance;
    logic        neg_x;
    logic        neg_y;
    logic        neg_z;
    logic        at;
  } dv_t;

  typedef struct packed {
    logic [17:0] dir_x;
    logic [17:0] dir_y;
    logic [17:0] dir_z;
    logic [32:0] distance;
    logic        at;
  } dl_t;

  // one restoring step: {ge, new remainder}
  function automatic logic [48:0] div_step(input logic [47:0] rem, input logic [48:0] dv);
    logic ge;
    ge = {1'b0, rem} >= dv;
    return {ge, ge ? rem - dv[47:0] : rem};
  endfunction

  function automatic logic [17:0] apply_sign(input logic [16:0] q, input logic neg,
                                             input logic at);
    logic [17:0] m;
    m = {1'b0, q};
    return at ? '0 : (neg ? -m : m);
  endfunction

  // ---------------- config ----------------
  logic [31:0] pos_x_r, pos_y_r, pos_z_r;
  coef_t       coef_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r  <= '0;
      pos_y_r  <= '0;
      pos_z_r  <= '0;
      coef_r.a <= '0;
      coef_r.b <= '0;
      coef_r.c <= CoefCReset;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_POS_X:  pos_x_r  <= cfg_data;
        CFG_POS_Y:  pos_y_r  <= cfg_data;
        CFG_POS_Z:  pos_z_r  <= cfg_data;
        CFG_COEF_A: coef_r.a <= cfg_data;
        CFG_COEF_B: coef_r.b <= cfg_data;
        CFG_COEF_C: coef_r.c <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- pipe control ----------------
  // whole pipe advances when the output register can take a word
  logic adv;
  logic out_valid_r;
  logic v1_r, v2_r, v3_r;
  logic sqv_r [SqrtStages];
  logic pv_r  [RecipLat];

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < SqrtStages; i++) sqv_r[i] <= 1'b0;
      for (int i = 0; i < RecipLat; i++) pv_r[i] <= 1'b0;
    end else if (adv) begin
      v1_r     <= in_tvalid;
      v2_r     <= v1_r;
      v3_r     <= v2_r;
      sqv_r[0] <= v3_r;
      for (int i = 1; i < SqrtStages; i++) sqv_r[i] <= sqv_r[i-1];
      pv_r[0]  <= sqv_r[SqrtStages-1];
      for (int i = 1; i < RecipLat; i++) pv_r[i] <= pv_r[i-1];
      out_valid_r <= pv_r[RecipLat-1];
    end
  end

  // ---------------- offset, squares, sum ----------------
  logic [32:0] dx, dy, dz;
  ofs_t        s1_nxt, s1_r, s2_r;
  logic [63:0] sqx_r, sqy_r, sqz_r;
  logic [65:0] sum_r;
  ofs_t        s3_r;

  always_comb begin
    dx = {pos_x_r[31], pos_x_r} - {in_tdata[31], in_tdata[31:0]};
    dy = {pos_y_r[31], pos_y_r} - {in_tdata[63], in_tdata[63:32]};
    dz = {pos_z_r[31], pos_z_r} - {in_tdata[95], in_tdata[95:64]};
    s1_nxt.neg_x = dx[32];
    s1_nxt.neg_y = dy[32];
    s1_nxt.neg_z = dz[32];
    // magnitude never exceeds 2^32-1
    s1_nxt.mag_x = dx[32] ? 32'(-dx) : dx[31:0];
    s1_nxt.mag_y = dy[32] ? 32'(-dy) : dy[31:0];
    s1_nxt.mag_z = dz[32] ? 32'(-dz) : dz[31:0];
    s1_nxt.at    = (dx == '0) && (dy == '0) && (dz == '0);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r  <= s1_nxt;
      sqx_r <= 64'(s1_r.mag_x) * 64'(s1_r.mag_x);
      sqy_r <= 64'(s1_r.mag_y) * 64'(s1_r.mag_y);
      sqz_r <= 64'(s1_r.mag_z) * 64'(s1_r.mag_z);
      s2_r  <= s1_r;
      sum_r <= 66'(sqx_r) + 66'(sqy_r) + 66'(sqz_r);
      s3_r  <= s2_r;
    end
  end

  // ---------------- square root, one root bit per stage ----------------
  sq_t sq_r [SqrtStages];

  for (genvar i = 0; i < SqrtStages; i++) begin : g_sqrt
    sq_t         src, nxt;
    logic [37:0] t, trial;
    logic        ge;
    if (i == 0) begin : g_first
      always_comb begin
        src      = '0;
        src.rad  = 68'(sum_r);
        src.o    = s3_r;
      end
    end else begin : g_rest
      assign src = sq_r[i-1];
    end
    always_comb begin
      t        = {src.rem, src.rad[67:66]};
      trial    = {2'b00, src.root, 2'b01};
      ge       = t >= trial;
      nxt      = src;
      nxt.rem  = ge ? 36'(t - trial) : t[35:0];
      nxt.root = {src.root[32:0], ge};
      nxt.rad  = {src.rad[65:0], 2'b00};
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        sq_r[i] <= nxt;
      end
    end
  end

  logic [32:0] dist_s;
  assign dist_s = sq_r[SqrtStages-1].root[32:0];

  // ---------------- direction: |v|*2^16 / d per lane ----------------
  dv_t dv_r [DirStages];

  for (genvar j = 0; j < DirStages; j++) begin : g_dir
    localparam int B = DirStages - 1 - j;
    dv_t         src, nxt;
    logic [48:0] dv, stx, sty, stz;
    if (j == 0) begin : g_first
      always_comb begin
        src          = '0;
        src.rem_x    = {sq_r[SqrtStages-1].o.mag_x, 16'b0};
        src.rem_y    = {sq_r[SqrtStages-1].o.mag_y, 16'b0};
        src.rem_z    = {sq_r[SqrtStages-1].o.mag_z, 16'b0};
        src.distance = dist_s;
        src.neg_x    = sq_r[SqrtStages-1].o.neg_x;
        src.neg_y    = sq_r[SqrtStages-1].o.neg_y;
        src.neg_z    = sq_r[SqrtStages-1].o.neg_z;
        src.at       = sq_r[SqrtStages-1].o.at;
      end
    end else begin : g_rest
      assign src = dv_r[j-1];
    end
    always_comb begin
      dv        = 49'(src.distance) << B;
      stx       = div_step(src.rem_x, dv);
      sty       = div_step(src.rem_y, dv);
      stz       = div_step(src.rem_z, dv);
      nxt       = src;
      nxt.rem_x = stx[47:0];
      nxt.rem_y = sty[47:0];
      nxt.rem_z = stz[47:0];
      nxt.q_x   = {src.q_x[15:0], stx[48]};
      nxt.q_y   = {src.q_y[15:0], sty[48]};
      nxt.q_z   = {src.q_z[15:0], stz[48]};
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_r[j] <= nxt;
      end
    end
  end

  // line up with the attenuation path
  dl_t dl_r [DirDelay];
  dl_t dl_nxt;

  always_comb begin
    dl_nxt.dir_x    = apply_sign(dv_r[DirStages-1].q_x, dv_r[DirStages-1].neg_x,
                                 dv_r[DirStages-1].at);
    dl_nxt.dir_y    = apply_sign(dv_r[DirStages-1].q_y, dv_r[DirStages-1].neg_y,
                                 dv_r[DirStages-1].at);
    dl_nxt.dir_z    = apply_sign(dv_r[DirStages-1].q_z, dv_r[DirStages-1].neg_z,
                                 dv_r[DirStages-1].at);
    dl_nxt.distance = dv_r[DirStages-1].distance;
    dl_nxt.at       = dv_r[DirStages-1].at;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dl_r[0] <= dl_nxt;
      for (int i = 1; i < DirDelay; i++) dl_r[i] <= dl_r[i-1];
    end
  end

  // ---------------- attenuation ----------------
  logic [31:0] atten_w;
  logic        sat_w;

  lva_recip u_recip (
    .clk     (clk),
    .en      (adv),
    .dist_i  (dist_s),
    .coef_i  (coef_r),
    .atten_o (atten_w),
    .sat_o   (sat_w)
  );

  // ---------------- output register ----------------
  logic [119:0] out_tdata_r;
  logic [1:0]   out_tuser_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      out_tdata_r <= {1'b0, atten_w, dl_r[DirDelay-1].distance, dl_r[DirDelay-1].dir_z,
                      dl_r[DirDelay-1].dir_y, dl_r[DirDelay-1].dir_x};
      out_tuser_r <= {dl_r[DirDelay-1].at, sat_w};
    end
  end

  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tvalid = out_valid_r;

  // ---------------- checks ----------------
`include "assert_macros.svh"

  `LVA_ASSERT_IMP(a_at_light_zero, out_tvalid && out_tuser[1], out_tdata[86:0] == '0)
  `LVA_ASSERT_IMP(a_sat_max, out_tvalid && out_tuser[0], out_tdata[118:87] == AttenMax)
  `LVA_ASSERT_IMP(a_stall_holds, out_tvalid && !out_tready, !in_tready)
  `LVA_ASSERT_RST(a_reset_empty, !out_tvalid)

endmodule
`default_nettype wire

/* dv/tb.sv */
`timescale 1ns / 1ps
module tb;
  import lva_pkg::*;

  // one expected result word
  typedef struct {
    logic [17:0] dir_x, dir_y, dir_z;
    logic [32:0] distance;
    logic [31:0] atten;
    logic        sat, at;
  } light_res_t;

  localparam logic [2:0] CFG_UNUSED = 3'd6;

  logic clk, rst_n;
  logic [95:0] in_tdata;
  logic in_tvalid, in_tready;
  logic [119:0] out_tdata;
  logic [1:0] out_tuser;
  logic out_tvalid, out_tready;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;

  light_vector_and_attenuation dut (.*);

  // shadow copy of the light registers
  logic [31:0] lpos [3];
  logic [31:0] coef_a, coef_b, coef_c;

  logic [95:0] point_q [$];   // points waiting to be driven
  light_res_t  light_q [$];   // results still owed by the block
  int errors = 0;
  int send_idle = 32, recv_idle = 58;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Exact integer version of distance, direction and 1/(a*d*d+b*d+c).
  function automatic light_res_t light_eval(logic [95:0] pt);
    light_res_t res;
    logic signed [33:0] ofs [3];
    logic [33:0] mag [3];
    logic [127:0] sum, den, quo, cand, q;
    logic [33:0] root;
    sum = 0;
    root = 0;
    for (int i = 0; i < 3; i++) begin
      ofs[i] = $signed({{2{lpos[i][31]}}, lpos[i]}) -
               $signed({{2{pt[32*i+31]}}, pt[32*i +: 32]});
      mag[i] = ofs[i] < 0 ? -ofs[i] : ofs[i];
      sum += 128'(mag[i]) * 128'(mag[i]);
    end
    res.at = (sum == 0);
    // bitwise floor square root, Q32.32 in, Q16.16 out
    for (int b = 33; b >= 0; b--) begin
      cand = 128'(root | (34'd1 << b));
      if (cand * cand <= sum) root = cand[33:0];
    end
    res.distance = root[32:0];
    den = 128'(coef_a) * 128'(root) * 128'(root) + ((128'(coef_b) * 128'(root)) << 16)
          + (128'(coef_c) << 32);
    res.sat = 0;
    if (den == 0) begin
      res.atten = AttenMax;
      res.sat = 1;
    end else begin
      quo = (128'd1 << 64) / den;
      if (quo > 128'(AttenMax)) begin
        res.atten = AttenMax;
        res.sat = 1;
      end else begin
        res.atten = quo[31:0];
      end
    end
    // truncate magnitude, then apply sign
    for (int i = 0; i < 3; i++) begin
      q = 0;
      if (!res.at && root != 0) begin
        q = (128'(mag[i]) << 16) / 128'(root);
        if (ofs[i] < 0) q = -q;
      end
      case (i)
        0: res.dir_x = q[17:0];
        1: res.dir_y = q[17:0];
        default: res.dir_z = q[17:0];
      endcase
    end
    return res;
  endfunction

  // driver: feed points, predict on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 0;
      in_tdata <= '0;
    end else begin
      if (in_tvalid && in_tready) light_q.push_back(light_eval(in_tdata));
      if ((!in_tvalid || in_tready)) begin
        if (point_q.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
          in_tvalid <= 1;
          in_tdata <= point_q.pop_front();
        end else begin
          in_tvalid <= 0;
        end
      end
    end
  end

  task automatic mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  // monitor: random backpressure, compare against oldest expectation
  always @(posedge clk) begin
    light_res_t w;
    if (!rst_n) begin
      out_tready <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (light_q.size() == 0) begin
          mismatch("unexpected word", 64'(out_tdata), 64'd0);
        end else begin
          w = light_q.pop_front();
          if (out_tdata[17:0] !== w.dir_x)
            mismatch("dir_x", 64'(out_tdata[17:0]), 64'(w.dir_x));
          if (out_tdata[35:18] !== w.dir_y)
            mismatch("dir_y", 64'(out_tdata[35:18]), 64'(w.dir_y));
          if (out_tdata[53:36] !== w.dir_z)
            mismatch("dir_z", 64'(out_tdata[53:36]), 64'(w.dir_z));
          if (out_tdata[86:54] !== w.distance)
            mismatch("distance", 64'(out_tdata[86:54]), 64'(w.distance));
          if (out_tdata[118:87] !== w.atten)
            mismatch("atten", 64'(out_tdata[118:87]), 64'(w.atten));
          if (out_tuser[0] !== w.sat)
            mismatch("atten_saturated", 64'(out_tuser[0]), 64'(w.sat));
          if (out_tuser[1] !== w.at)
            mismatch("at_light", 64'(out_tuser[1]), 64'(w.at));
        end
      end
      out_tready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  task automatic wait_drained();
    wait (point_q.size() == 0 && !in_tvalid && light_q.size() == 0);
    repeat (80) @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    case (idx)
      CFG_POS_X:  lpos[0] = val;
      CFG_POS_Y:  lpos[1] = val;
      CFG_POS_Z:  lpos[2] = val;
      CFG_COEF_A: coef_a = val;
      CFG_COEF_B: coef_b = val;
      CFG_COEF_C: coef_c = val;
      default: ;
    endcase
  endtask

  task automatic set_light(logic [31:0] x, y, z, a, b, c);
    wait_drained();
    reg_write(CFG_POS_X, x);
    reg_write(CFG_POS_Y, y);
    reg_write(CFG_POS_Z, z);
    reg_write(CFG_COEF_A, a);
    reg_write(CFG_COEF_B, b);
    reg_write(CFG_COEF_C, c);
  endtask

  // random point: anywhere, close to the light, on it, at extremes or near the origin
  task automatic push_random_point();
    logic [31:0] p [3];
    int kind;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 3; i++) begin
      case (kind)
        0, 1, 2, 3: p[i] = $urandom;
        4, 5: p[i] = lpos[i] + $urandom_range(0, 64) - 32;
        6: p[i] = lpos[i] + $urandom_range(0, 1 << 20) - (1 << 19);
        7: p[i] = lpos[i];
        8: p[i] = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        default: p[i] = {{16{1'b0}}, 16'($urandom)} - 32'h8000;
      endcase
    end
    point_q.push_back({p[2], p[1], p[0]});
  endtask

  initial begin
    rst_n = 0;
    cfg_valid = 0;
    cfg_index = CFG_POS_X;
    cfg_data = 0;
    lpos[0] = 0; lpos[1] = 0; lpos[2] = 0;
    coef_a = 0; coef_b = 0; coef_c = CoefCReset;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // reset settings: on the light, axis extremes, tiny offsets
    point_q.push_back(96'h0);
    point_q.push_back({32'h0, 32'h0, 32'h7FFF_FFFF});
    point_q.push_back({32'h0, 32'h8000_0000, 32'h0});
    point_q.push_back({32'h8000_0000, 32'h0, 32'h0});
    point_q.push_back({32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    point_q.push_back({32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
    point_q.push_back({32'h0, 32'h0, 32'h1});
    point_q.push_back({32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF});
    point_q.push_back({32'h0001_0000, 32'hFFFF_0000, 32'h0003_0000});

    // ignored index, light in opposite corner, zero denominator
    wait_drained();
    reg_write(CFG_UNUSED, 32'hDEAD_BEEF);
    reg_write(CFG_UNUSED + 3'd1, 32'h1234_5678);
    set_light(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0);
    point_q.push_back({32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000});
    point_q.push_back({32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF});
    point_q.push_back(96'h0);

    // quadratic only: on the light the denominator is zero
    set_light(0, 0, 0, 32'h0001_0000, 0, 0);
    point_q.push_back(96'h0);
    point_q.push_back({32'h0, 32'h0, 32'h0000_0001});
    point_q.push_back({32'h0, 32'h0, 32'h0010_0000});

    // all coefficients maximal: quotient truncates to one on the light, to zero far off
    set_light(0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    point_q.push_back(96'h0);
    point_q.push_back({32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});

    // tiny constant: attenuation clips
    set_light(0, 0, 0, 0, 0, 32'h1);
    point_q.push_back(96'h0);
    point_q.push_back({32'h0, 32'h0, 32'h1});

    // random part, idling mode changes every third of the phases
    for (int ph = 0; ph < 9; ph++) begin
      case (ph % 4)
        0: set_light($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        1: set_light($urandom, $urandom, $urandom, $urandom_range(0, 1 << 18),
                     $urandom_range(0, 1 << 18), $urandom_range(1, 1 << 17));
        2: set_light($urandom_range(0, 1 << 20), $urandom, 32'h8000_0000, 0,
                     $urandom_range(0, 1 << 16), $urandom_range(0, 4));
        default: set_light($urandom, 0, $urandom, $urandom_range(0, 64), 0, 0);
      endcase
      if (ph < 3) begin
        send_idle = 32; recv_idle = 58;
      end else if (ph < 6) begin
        send_idle = 58; recv_idle = 32;
      end else begin
        send_idle = 0; recv_idle = 0;
      end
      for (int k = 0; k < 120; k++) begin
        push_random_point();
        // sender holds off until the pipe has fully emptied
        if (ph == 4 && k == 60) wait_drained();
      end
    end

    wait_drained();
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("tb failed");
    $finish;
  end

endmodule

/* light_vector_and_attenuation.f */
+incdir+rtl/core
rtl/core/lva_pkg.sv
rtl/core/lva_recip.sv
rtl/core/light_vector_and_attenuation.sv
dv/tb.sv
